/* rtl/qsalu_pkg.sv */
// Shared types, codes and helpers for the Q8.8 saturating ALU.
package qsalu_pkg;

   localparam int Q_W         = 16;
   localparam int Q_FRAC_BITS = 8;
   localparam int MODE_W      = 3;
   // Dividend is |a| scaled by 2^8, so one quotient bit per cell over its full width.
   localparam int DIV_STEPS   = Q_W + Q_FRAC_BITS;
   // Partial remainder stays below |b| <= 2^15.
   localparam int REM_W       = Q_W - 1;

   localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
   localparam logic [MODE_W-1:0] MODE_INT = 3'd4;

   localparam logic signed [31:0] Q_MIN = -32'sd32768;
   localparam logic signed [31:0] Q_MAX = 32'sd32767;

   // One in-flight transaction as it moves down the divider chain.
   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 neg;
      logic                 dz;
      logic [Q_W-1:0]       result;
      logic [Q_W-1:0]       divisor;
      logic [REM_W-1:0]     rem;
      logic [DIV_STEPS-1:0] dq;
   } cell_type;

   function automatic logic [Q_W-1:0] sat_q(input logic signed [31:0] v);
      logic [Q_W-1:0] r;
      if (v < Q_MIN) begin
         r = 16'h8000;
      end else if (v > Q_MAX) begin
         r = 16'h7fff;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [Q_W-1:0] abs_q(input logic [Q_W-1:0] v);
      logic [Q_W-1:0] r;
      r = v[Q_W-1] ? (~v + 16'd1) : v;
      return r;
   endfunction

endpackage

/* rtl/qsalu_if.sv */
// Valid/ready channel interfaces for the request and response sides of the ALU.
interface qsalu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [qsalu_pkg::MODE_W-1:0]         mode;
   logic signed [qsalu_pkg::Q_W-1:0]     operand_a;
   logic signed [qsalu_pkg::Q_W-1:0]     operand_b;

   modport source(output valid, mode, operand_a, operand_b, input ready);
   modport sink(input valid, mode, operand_a, operand_b, output ready);
endinterface

interface qsalu_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qsalu_pkg::Q_W-1:0]     result;
   logic                                 div_by_zero;

   modport source(output valid, result, div_by_zero, input ready);
   modport sink(input valid, result, div_by_zero, output ready);
endinterface

/* rtl/qsalu_prep.sv */
// Front end: registered multiply, then non-divide results and divider setup.
module qsalu_prep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [qsalu_pkg::MODE_W-1:0]     in_mode,
   input  logic [qsalu_pkg::Q_W-1:0]        in_a,
   input  logic [qsalu_pkg::Q_W-1:0]        in_b,
   output qsalu_pkg::cell_type              out_cell
);

   logic                             valid_a_ff;
   logic [qsalu_pkg::MODE_W-1:0]     mode_a_ff;
   logic [qsalu_pkg::Q_W-1:0]        a_a_ff;
   logic [qsalu_pkg::Q_W-1:0]        b_a_ff;
   logic signed [31:0]               prod_a_ff;
   logic signed [31:0]               prod_a_in;

   qsalu_pkg::cell_type              cell_ff;
   qsalu_pkg::cell_type              cell_in;

   logic signed [31:0]               a_ext;
   logic signed [31:0]               b_ext;
   logic [qsalu_pkg::Q_W-1:0]        abs_a;

   assign prod_a_in = $signed(in_a) * $signed(in_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
      end
      if (advance) begin
         mode_a_ff <= in_mode;
         a_a_ff    <= in_a;
         b_a_ff    <= in_b;
         prod_a_ff <= prod_a_in;
      end
   end

   assign a_ext = 32'($signed(a_a_ff));
   assign b_ext = 32'($signed(b_a_ff));
   assign abs_a = qsalu_pkg::abs_q(a_a_ff);

   always_comb begin
      cell_in         = '0;
      cell_in.valid   = valid_a_ff;
      cell_in.is_div  = (mode_a_ff == qsalu_pkg::MODE_DIV);
      cell_in.neg     = a_a_ff[qsalu_pkg::Q_W-1] ^ b_a_ff[qsalu_pkg::Q_W-1];
      cell_in.dz      = (mode_a_ff == qsalu_pkg::MODE_DIV) && (b_a_ff == '0);
      cell_in.divisor = qsalu_pkg::abs_q(b_a_ff);
      cell_in.rem     = '0;
      cell_in.dq      = {abs_a, {qsalu_pkg::Q_FRAC_BITS{1'b0}}};
      case (mode_a_ff)
         qsalu_pkg::MODE_ADD: begin
            cell_in.result = qsalu_pkg::sat_q(a_ext + b_ext);
         end
         qsalu_pkg::MODE_SUB: begin
            cell_in.result = qsalu_pkg::sat_q(a_ext - b_ext);
         end
         qsalu_pkg::MODE_MUL: begin
            // arithmetic shift rounds toward minus infinity
            cell_in.result = qsalu_pkg::sat_q(prod_a_ff >>> qsalu_pkg::Q_FRAC_BITS);
         end
         qsalu_pkg::MODE_INT: begin
            cell_in.result = qsalu_pkg::sat_q(a_ext <<< qsalu_pkg::Q_FRAC_BITS);
         end
         default: begin
            cell_in.result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign out_cell = cell_ff;

endmodule

/* rtl/qsalu_div_cell.sv */
// One restoring-division cell: resolves one quotient bit and passes the transaction on.
module qsalu_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  qsalu_pkg::cell_type   in_cell,
   output qsalu_pkg::cell_type   out_cell
);

   qsalu_pkg::cell_type          cell_ff;
   qsalu_pkg::cell_type          cell_in;
   logic [qsalu_pkg::Q_W-1:0]    shifted;
   logic [qsalu_pkg::Q_W:0]      diff;
   logic                         q_bit;

   // bring the next dividend bit into the partial remainder
   assign shifted = {in_cell.rem, in_cell.dq[qsalu_pkg::DIV_STEPS-1]};
   assign diff    = {1'b0, shifted} - {1'b0, in_cell.divisor};
   assign q_bit   = ~diff[qsalu_pkg::Q_W];

   always_comb begin
      cell_in     = in_cell;
      cell_in.rem = q_bit ? diff[qsalu_pkg::REM_W-1:0] : shifted[qsalu_pkg::REM_W-1:0];
      cell_in.dq  = {in_cell.dq[qsalu_pkg::DIV_STEPS-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign out_cell = cell_ff;

endmodule

/* rtl/qsalu_post.sv */
// Back end: signs and clamps the quotient, selects the result, holds the output register.
module qsalu_post (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  qsalu_pkg::cell_type          in_cell,
   output logic                         out_valid,
   output logic [qsalu_pkg::Q_W-1:0]    out_result,
   output logic                         out_dz
);

   logic                              valid_ff;
   logic [qsalu_pkg::Q_W-1:0]         result_ff;
   logic [qsalu_pkg::Q_W-1:0]         result_in;
   logic                              dz_ff;
   logic [qsalu_pkg::DIV_STEPS-1:0]   q;
   logic [qsalu_pkg::DIV_STEPS-1:0]   q_neg;

   assign q     = in_cell.dq;
   assign q_neg = ~q + 24'd1;

   always_comb begin
      if (!in_cell.is_div) begin
         result_in = in_cell.result;
      end else if (in_cell.dz) begin
         result_in = '0;
      end else if (in_cell.neg) begin
         result_in = (q > 24'd32768) ? 16'h8000 : q_neg[qsalu_pkg::Q_W-1:0];
      end else begin
         result_in = (q > 24'd32767) ? 16'h7fff : q[qsalu_pkg::Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_cell.valid;
      end
      if (advance) begin
         result_ff <= result_in;
         dz_ff     <= in_cell.dz;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_dz     = dz_ff;

endmodule

/* rtl/q8_8_saturating_alu.sv */
// Q8.8 saturating ALU: add, subtract, multiply, divide and integer conversion.
// Accepts one transaction per clock unless the output stalls, and returns results in
// order through 27 register stages, namely two front-end stages (multiply, then result
// selection and divider setup), a chain of 24 divider cells resolving one quotient bit
// each, and the output register. Every transaction flows through the full chain, so
// latency is the same for all modes. While a response waits on rsp_chan.ready the whole
// pipeline holds and req_chan.ready drops; an empty output register keeps it moving.
module q8_8_saturating_alu (
   input  logic           clock,
   input  logic           reset,
   qsalu_req_if.sink      req_chan,
   qsalu_rsp_if.source    rsp_chan
);

   logic                              advance;
   qsalu_pkg::cell_type               chain [0:qsalu_pkg::DIV_STEPS];
   logic [qsalu_pkg::Q_W-1:0]         rsp_result;

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   qsalu_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_chan.valid),
      .in_mode  (req_chan.mode),
      .in_a     (req_chan.operand_a),
      .in_b     (req_chan.operand_b),
      .out_cell (chain[0])
   );

   for (genvar k = 0; k < qsalu_pkg::DIV_STEPS; k++) begin : g_cell
      qsalu_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_cell  (chain[k]),
         .out_cell (chain[k+1])
      );
   end

   qsalu_post u_post (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_cell    (chain[qsalu_pkg::DIV_STEPS]),
      .out_valid  (rsp_chan.valid),
      .out_result (rsp_result),
      .out_dz     (rsp_chan.div_by_zero)
   );

   assign rsp_chan.result = rsp_result;

   // divide-by-zero responses always carry a zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.div_by_zero |-> rsp_chan.result == '0)
      else $error("div_by_zero response with nonzero result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

   // a finished division leaves a remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      chain[qsalu_pkg::DIV_STEPS].valid && chain[qsalu_pkg::DIV_STEPS].is_div &&
      !chain[qsalu_pkg::DIV_STEPS].dz |->
      {1'b0, chain[qsalu_pkg::DIV_STEPS].rem} < chain[qsalu_pkg::DIV_STEPS].divisor)
      else $error("divider remainder not below divisor");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the Q8.8 saturating ALU: directed corners, then random traffic.
module tb_top;

   localparam logic [qsalu_pkg::MODE_W-1:0] MODE_TOP = 3'd7;   // highest code, unused like 5 and 6
   localparam int                CYCLE_LIMIT = 200000;
   localparam int                DRAIN_CYCLES = 40;  // pipeline is 27 deep
   localparam int                REPORT_MAX = 10;

   typedef struct packed {
      logic signed [qsalu_pkg::Q_W-1:0] result;
      logic                             div_by_zero;
   } q88_result_type;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   bad_results = 0;
   int   cycles = 0;

   q88_result_type pending_results[$];

   qsalu_req_if req_chan ();
   qsalu_rsp_if rsp_chan ();

   q8_8_saturating_alu dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Saturating Q8.8 arithmetic, worked at 64 bits then clamped.
   function automatic q88_result_type compute_q88(
      input logic [qsalu_pkg::MODE_W-1:0]     op,
      input logic signed [qsalu_pkg::Q_W-1:0] a,
      input logic signed [qsalu_pkg::Q_W-1:0] b);
      q88_result_type r;
      longint         full;
      r.div_by_zero = 1'b0;
      full = 0;
      case (op)
         qsalu_pkg::MODE_ADD: full = longint'(a) + longint'(b);
         qsalu_pkg::MODE_SUB: full = longint'(a) - longint'(b);
         qsalu_pkg::MODE_MUL: full = (longint'(a) * longint'(b)) >>> qsalu_pkg::Q_FRAC_BITS;
         qsalu_pkg::MODE_DIV: begin
            if (b == 0) begin
               r.div_by_zero = 1'b1;
            end else begin
               full = (longint'(a) <<< qsalu_pkg::Q_FRAC_BITS) / longint'(b);
            end
         end
         qsalu_pkg::MODE_INT: full = longint'(a) <<< qsalu_pkg::Q_FRAC_BITS;
         default: full = 0;
      endcase
      if (full < longint'(qsalu_pkg::Q_MIN)) begin
         r.result = 16'sh8000;
      end else if (full > longint'(qsalu_pkg::Q_MAX)) begin
         r.result = 16'sh7fff;
      end else begin
         r.result = full[qsalu_pkg::Q_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [qsalu_pkg::Q_W-1:0] rand_q();
      logic signed [qsalu_pkg::Q_W-1:0] v;
      case ($urandom_range(7))
         0: v = 16'sh8000;
         1: v = 16'sh7fff;
         2: v = 16'($urandom_range(1023) - 512);
         3: v = $urandom_range(1) ? -16'sd1 : 16'sd1;
         4: v = $urandom_range(1) ? -16'sd256 : 16'sd256;
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_op(input logic [qsalu_pkg::MODE_W-1:0]     op,
                          input logic signed [qsalu_pkg::Q_W-1:0] a,
                          input logic signed [qsalu_pkg::Q_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= op;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(compute_q88(op, a, b));
   endtask

   // Result side: check each accepted transaction, then pick next cycle's ready.
   always @(posedge clock) begin
      q88_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               bad_results = bad_results + 1;
               if (bad_results <= REPORT_MAX)
                  $display("unexpected result %0d dz %0b", rsp_chan.result,
                           rsp_chan.div_by_zero);
            end else begin
               want = pending_results.pop_front();
               if (rsp_chan.result !== want.result ||
                   rsp_chan.div_by_zero !== want.div_by_zero) begin
                  bad_results = bad_results + 1;
                  if (bad_results <= REPORT_MAX)
                     $display("mismatch: expected result %0d dz %0b, got result %0d dz %0b",
                              want.result, want.div_by_zero, rsp_chan.result,
                              rsp_chan.div_by_zero);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic test_directed();
      send_op(qsalu_pkg::MODE_ADD, 16'sh7fff, 16'sh7fff);
      send_op(qsalu_pkg::MODE_ADD, 16'sh8000, 16'sh8000);
      send_op(qsalu_pkg::MODE_ADD, 16'sd1, -16'sd1);
      send_op(qsalu_pkg::MODE_SUB, 16'sh8000, 16'sh7fff);
      send_op(qsalu_pkg::MODE_SUB, 16'sh7fff, 16'sh8000);
      send_op(qsalu_pkg::MODE_MUL, 16'sh7fff, 16'sh7fff);
      send_op(qsalu_pkg::MODE_MUL, 16'sh8000, 16'sh8000);
      send_op(qsalu_pkg::MODE_MUL, 16'sh8000, 16'sh7fff);
      send_op(qsalu_pkg::MODE_MUL, -16'sd1, 16'sd1);          // floors to -1
      send_op(qsalu_pkg::MODE_MUL, 16'sh0180, 16'sh0180);
      send_op(qsalu_pkg::MODE_DIV, 16'sd100, 16'sd0);
      send_op(qsalu_pkg::MODE_DIV, 16'sd0, 16'sd0);
      send_op(qsalu_pkg::MODE_DIV, 16'sh8000, -16'sd1);       // overflow clamps high
      send_op(qsalu_pkg::MODE_DIV, 16'sd256, 16'sd3);
      send_op(qsalu_pkg::MODE_DIV, -16'sd256, 16'sd3);        // truncates toward zero
      send_op(qsalu_pkg::MODE_DIV, 16'sd1, 16'sh7fff);
      send_op(qsalu_pkg::MODE_INT, 16'sd127, 16'sd0);
      send_op(qsalu_pkg::MODE_INT, 16'sd128, 16'sh7fff);
      send_op(qsalu_pkg::MODE_INT, -16'sd128, 16'sh8000);
      send_op(qsalu_pkg::MODE_INT, -16'sd129, 16'sd5);
      send_op(qsalu_pkg::MODE_INT, 16'sh8000, 16'sd0);
      for (int m = qsalu_pkg::MODE_INT + 1; m <= MODE_TOP; m++)
         send_op(m[qsalu_pkg::MODE_W-1:0], rand_q(), 16'sd0);  // unused codes
   endtask

   task automatic test_add_sub(input int n);
      for (int i = 0; i < n; i++)
         send_op($urandom_range(1) ? qsalu_pkg::MODE_ADD : qsalu_pkg::MODE_SUB,
                 rand_q(), rand_q());
   endtask

   task automatic test_multiply(input int n);
      for (int i = 0; i < n; i++)
         send_op(qsalu_pkg::MODE_MUL, rand_q(), rand_q());
   endtask

   task automatic test_divide(input int n);
      for (int i = 0; i < n; i++)
         send_op(qsalu_pkg::MODE_DIV, rand_q(),
                 ($urandom_range(15) == 0) ? 16'sd0 : rand_q());
   endtask

   task automatic test_int_to_q(input int n);
      logic signed [qsalu_pkg::Q_W-1:0] a;
      for (int i = 0; i < n; i++) begin
         a = $urandom_range(1) ? 16'($urandom_range(511) - 256) : rand_q();
         send_op(qsalu_pkg::MODE_INT, a, 16'($urandom));
      end
   endtask

   task automatic test_unused_modes(input int n);
      for (int i = 0; i < n; i++)
         send_op(3'($urandom_range(MODE_TOP, qsalu_pkg::MODE_INT + 1)),
                 16'($urandom), 16'($urandom));
   endtask

   task automatic test_mixed(input int n);
      logic [qsalu_pkg::MODE_W-1:0] op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(15) == 0)
              ? 3'($urandom_range(MODE_TOP, qsalu_pkg::MODE_INT + 1))
              : 3'($urandom_range(qsalu_pkg::MODE_INT));
         send_op(op, rand_q(),
                 (op == qsalu_pkg::MODE_DIV && $urandom_range(15) == 0) ? 16'sd0 : rand_q());
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.mode      = qsalu_pkg::MODE_ADD;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      send_idle_pct      = 33;
      recv_idle_pct      = 76;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_add_sub(250);
      test_multiply(250);

      send_idle_pct = 76;
      recv_idle_pct = 33;
      test_divide(300);
      test_int_to_q(150);
      test_unused_modes(50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_mixed(700);
      req_chan.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_results == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
